### sv/mcfir_pkg.sv
`default_nettype none
package mcfir_pkg;

    // Default sizes of the delay lines and the coefficient table
    localparam int DEF_MAX_TAPS     = 1024;
    localparam int DEF_MAX_CHANNELS = 8;

    // Field widths
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 24;
    localparam int CIDX_W     = 10;
    localparam int COEFF_W    = 18;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int ACC_W      = 48;
    localparam int NTAPS_W    = 11;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Rounding: Q2.40 products down to Q1.23
    localparam int RND_SHIFT = 17;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_TAPS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 1'd1;

    // Configuration reset values
    localparam logic [NTAPS_W-1:0] NUM_TAPS_RESET = 11'd15;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUTE   = 2'd2;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic issue;
    } mac_ctrl_t;

    typedef struct packed {
        logic                       busy;
        logic signed [SAMPLE_W-1:0] result;
    } mac_stat_t;

endpackage
`default_nettype wire

### sv/mcfir_ram.sv
`default_nettype none
module mcfir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/mcfir_mac.sv
`default_nettype none
module mcfir_mac (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire mcfir_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [mcfir_pkg::SAMPLE_W-1:0]   smp_rdata,
    input  wire logic signed [mcfir_pkg::COEFF_W-1:0]    coef_rdata,
    output      mcfir_pkg::mac_stat_t                    stat
);

    logic                                  rd_vld_reg;
    logic                                  prod_vld_reg;
    logic signed [mcfir_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mcfir_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mcfir_pkg::ACC_W:0]      rnd_sum;
    logic signed [31:0]                    rnd_q;

    // Memory data lands in the cycle after the address was issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= ctrl.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= smp_rdata * coef_rdata;
        end
        if (ctrl.clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + mcfir_pkg::ACC_W'(prod_reg);
        end
    end

    // Round half up, then saturate to Q1.23
    always_comb begin
        rnd_sum = (mcfir_pkg::ACC_W+1)'(acc_reg)
                  + (mcfir_pkg::ACC_W+1)'(65536);
        rnd_q   = 32'(rnd_sum >>> mcfir_pkg::RND_SHIFT);
        stat.busy = rd_vld_reg | prod_vld_reg;
        if (rnd_q > 32'sd8388607) begin
            stat.result = 24'sh7FFFFF;
        end else if (rnd_q < -32'sd8388608) begin
            stat.result = 24'sh800000;
        end else begin
            stat.result = rnd_q[mcfir_pkg::SAMPLE_W-1:0];
        end
    end

endmodule
`default_nettype wire

### sv/multichannel_fir_filter.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata, s_tuser (kind), s_tlast (block end)
// m_        out        m_tvalid/m_tready  m_tdata, m_tlast (block end)
// cfg_      in         cfg_we             cfg_addr, cfg_wdata
//
// A filter-mode sample holds the block through accept, decode/write, one multiply-accumulate
// per clamped tap (one read port per memory), the drain of the MAC pipeline and the output
// load. Pass-through and mute samples go through accept, decode and the output load,
// coefficient writes through accept and decode only, one item at a time. After reset both
// memories are swept to zero with s_tready low; a stalled m_ side holds only the final output load.
module multichannel_fir_filter #(
    parameter int MAX_TAPS     = mcfir_pkg::DEF_MAX_TAPS,
    parameter int MAX_CHANNELS = mcfir_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    // [2:0] channel, [26:3] sample, [36:27] coeff_index, [54:37] coeff_value
    input  wire logic [mcfir_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] req_type
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tlast,
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // [2:0] out_channel, [26:3] filtered
    output      logic [mcfir_pkg::M_TDATA_W-1:0]      m_tdata,
    output      logic                                 m_tlast,
    input  wire logic                                 cfg_we,
    input  wire logic [mcfir_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mcfir_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int DEPTH = MAX_CHANNELS * MAX_TAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_TAPS);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW    = (TW + 1 > mcfir_pkg::NTAPS_W) ? TW + 1 : mcfir_pkg::NTAPS_W;

    mcfir_pkg::state_t state_reg, state_next;

    // Latched item
    logic                                    req_reg;
    logic [mcfir_pkg::CH_W-1:0]              ch_reg;
    logic signed [mcfir_pkg::SAMPLE_W-1:0]   smp_reg;
    logic [mcfir_pkg::CIDX_W-1:0]            cidx_reg;
    logic [mcfir_pkg::COEFF_W-1:0]           cval_reg;
    logic                                    last_reg;
    logic [AW-1:0]                           base_reg;

    // Tap walk
    logic [TW-1:0] pos_reg;
    logic [TW-1:0] k_reg;
    logic [TW-1:0] klast_reg;
    logic [TW-1:0] wp_reg [MAX_CHANNELS];
    logic [AW-1:0] clr_cnt_reg;

    // Configuration
    logic [mcfir_pkg::NTAPS_W-1:0] num_taps_reg;
    logic [mcfir_pkg::MODE_W-1:0]  mode_reg;

    // Output register
    logic                                    m_tvalid_reg;
    logic [mcfir_pkg::CH_W-1:0]              m_ch_reg;
    logic [mcfir_pkg::SAMPLE_W-1:0]          m_filt_reg;
    logic                                    m_last_reg;

    logic [CHW-1:0] ch_idx;
    logic           ch_ok;
    logic           cidx_ok;
    logic [TW-1:0]  wp_cur;
    logic [TW-1:0]  wp_new;
    logic           out_free;
    logic [NW-1:0]  ntaps;
    logic [TW-1:0]  klast_calc;
    logic           s_xfer;

    // Memory ports
    logic                                 dly_we;
    logic [AW-1:0]                        dly_waddr;
    logic [mcfir_pkg::SAMPLE_W-1:0]       dly_wdata;
    logic [AW-1:0]                        dly_raddr;
    logic [mcfir_pkg::SAMPLE_W-1:0]       dly_rdata;
    logic                                 coef_we;
    logic [TW-1:0]                        coef_waddr;
    logic [mcfir_pkg::COEFF_W-1:0]        coef_wdata;
    logic [TW-1:0]                        coef_raddr;
    logic [mcfir_pkg::COEFF_W-1:0]        coef_rdata;

    mcfir_pkg::mac_ctrl_t mac_ctrl;
    mcfir_pkg::mac_stat_t mac_stat;

    mcfir_ram #(
        .WIDTH (mcfir_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_dly_ram (
        .aclk  (aclk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    mcfir_ram #(
        .WIDTH (mcfir_pkg::COEFF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    mcfir_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mac_ctrl),
        .smp_rdata  (dly_rdata),
        .coef_rdata (coef_rdata),
        .stat       (mac_stat)
    );

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ch_idx   = CHW'(ch_reg);
    assign ch_ok    = (32'(ch_reg) < MAX_CHANNELS);
    assign cidx_ok  = (32'(cidx_reg) < MAX_TAPS);
    assign wp_cur   = wp_reg[ch_idx];
    assign wp_new   = (wp_cur == TW'(MAX_TAPS - 1)) ? '0 : wp_cur + 1'b1;

    // Clamp the tap count to 1 .. MAX_TAPS and keep the last tap index
    always_comb begin
        ntaps = NW'(num_taps_reg);
        if (ntaps == '0) begin
            klast_calc = '0;
        end else if (ntaps > NW'(MAX_TAPS)) begin
            klast_calc = TW'(MAX_TAPS - 1);
        end else begin
            klast_calc = TW'(ntaps - 1'b1);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcfir_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = mcfir_pkg::ST_IDLE;
                end
            end
            mcfir_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mcfir_pkg::ST_DECODE;
                end
            end
            mcfir_pkg::ST_DECODE: begin
                if (req_reg == mcfir_pkg::REQ_COEFF || !ch_ok) begin
                    state_next = mcfir_pkg::ST_IDLE;
                end else if (mode_reg == mcfir_pkg::MODE_FILTER) begin
                    state_next = mcfir_pkg::ST_RUN;
                end else begin
                    state_next = mcfir_pkg::ST_EMIT;
                end
            end
            mcfir_pkg::ST_RUN: begin
                if (k_reg == klast_reg) begin
                    state_next = mcfir_pkg::ST_DRAIN;
                end
            end
            mcfir_pkg::ST_DRAIN: begin
                if (!mac_stat.busy) begin
                    state_next = mcfir_pkg::ST_EMIT;
                end
            end
            mcfir_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = mcfir_pkg::ST_IDLE;
                end
            end
            default: state_next = mcfir_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports, MAC control, input ready
    always_comb begin
        s_tready       = 1'b0;
        dly_we         = 1'b0;
        dly_waddr      = clr_cnt_reg;
        dly_wdata      = '0;
        dly_raddr      = base_reg + AW'(pos_reg);
        coef_we        = 1'b0;
        coef_waddr     = TW'(clr_cnt_reg);
        coef_wdata     = '0;
        coef_raddr     = k_reg;
        mac_ctrl.clr   = 1'b0;
        mac_ctrl.issue = 1'b0;
        case (state_reg)
            mcfir_pkg::ST_CLEAR: begin
                // Sweep both memories to zero; the coefficient address wraps harmlessly
                dly_we  = 1'b1;
                coef_we = 1'b1;
            end
            mcfir_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            mcfir_pkg::ST_DECODE: begin
                coef_we      = (req_reg == mcfir_pkg::REQ_COEFF) && cidx_ok;
                coef_waddr   = TW'(cidx_reg);
                coef_wdata   = cval_reg;
                // Push the new sample at the advanced write pointer
                dly_we       = (req_reg == mcfir_pkg::REQ_SAMPLE) && ch_ok
                               && (mode_reg == mcfir_pkg::MODE_FILTER);
                dly_waddr    = base_reg + AW'(wp_new);
                dly_wdata    = smp_reg;
                mac_ctrl.clr = 1'b1;
            end
            mcfir_pkg::ST_RUN: begin
                mac_ctrl.issue = 1'b1;
            end
            mcfir_pkg::ST_DRAIN: begin
            end
            mcfir_pkg::ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcfir_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            num_taps_reg <= mcfir_pkg::NUM_TAPS_RESET;
            mode_reg     <= mcfir_pkg::MODE_PASS;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                wp_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == mcfir_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    mcfir_pkg::CFG_NUM_TAPS: num_taps_reg <= cfg_wdata;
                    mcfir_pkg::CFG_MODE:     mode_reg <= cfg_wdata[mcfir_pkg::MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == mcfir_pkg::ST_DECODE && req_reg == mcfir_pkg::REQ_SAMPLE
                && ch_ok && mode_reg == mcfir_pkg::MODE_FILTER) begin
                wp_reg[ch_idx] <= wp_new;
            end
            // Load a new result when there is room, else drop the one just taken
            if (state_reg == mcfir_pkg::ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg  <= s_tuser;
            ch_reg   <= s_tdata[2:0];
            smp_reg  <= s_tdata[26:3];
            cidx_reg <= s_tdata[36:27];
            cval_reg <= s_tdata[54:37];
            last_reg <= s_tlast;
            base_reg <= AW'(32'(s_tdata[2:0]) * MAX_TAPS);
        end
        if (state_reg == mcfir_pkg::ST_DECODE) begin
            pos_reg   <= wp_new;
            k_reg     <= '0;
            klast_reg <= klast_calc;
        end else if (state_reg == mcfir_pkg::ST_RUN) begin
            // Walk back through the circular line, newest sample first
            k_reg   <= k_reg + 1'b1;
            pos_reg <= (pos_reg == '0) ? TW'(MAX_TAPS - 1) : pos_reg - 1'b1;
        end
        if (state_reg == mcfir_pkg::ST_EMIT && out_free) begin
            m_ch_reg   <= ch_reg;
            m_last_reg <= last_reg;
            case (mode_reg)
                mcfir_pkg::MODE_FILTER: m_filt_reg <= mac_stat.result;
                mcfir_pkg::MODE_PASS:   m_filt_reg <= smp_reg;
                default:                m_filt_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mcfir_pkg::M_TDATA_W - mcfir_pkg::SAMPLE_W - mcfir_pkg::CH_W){1'b0}},
                       m_filt_reg, m_ch_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // A filtered result is loaded only after every product has reached the accumulator
    a_emit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcfir_pkg::ST_EMIT && mode_reg == mcfir_pkg::MODE_FILTER)
        |-> !mac_stat.busy)
        else $error("result loaded while MAC pipeline busy");

    // The tap walk never runs past the clamped tap count
    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcfir_pkg::ST_RUN) |-> (k_reg <= klast_reg))
        else $error("tap index past last tap");

    // A finished filter walk hands over to the drain wait
    a_run_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcfir_pkg::ST_RUN && k_reg == klast_reg)
        |=> (state_reg == mcfir_pkg::ST_DRAIN && mac_stat.busy))
        else $error("tap walk did not end in drain");
`endif

endmodule
`default_nettype wire

### sim/multichannel_fir_filter_checker.sv
module multichannel_fir_filter_checker
    import mcfir_pkg::*;
#(
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // [2:0] channel, [26:3] sample, [36:27] coeff_index, [54:37] coeff_value
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [2:0] out_channel, [26:3] filtered
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         errors,
    output int                         pending,
    output int                         results
);

    localparam int CIDX_LO = CH_W + SAMPLE_W;
    localparam int CVAL_LO = CIDX_LO + CIDX_W;
    localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } filtered_t;

    logic signed [SAMPLE_W-1:0] history [MAX_CHANNELS*MAX_TAPS];
    int                         newest  [MAX_CHANNELS];
    logic signed [COEFF_W-1:0]  taps    [MAX_TAPS];
    logic [NTAPS_W-1:0]         tap_count;
    logic [MODE_W-1:0]          band_mode;
    filtered_t                  expected_out [$];
    int                         mismatch_count = 0;
    int                         result_count   = 0;

    // Newest sample times tap 0, going back in time around the circular line.
    function automatic logic signed [SAMPLE_W-1:0] fir_output(int ch);
        int                       n;
        int                       pos;
        logic signed [PROD_W-1:0] prod;
        logic [ACC_W-1:0]         acc;
        longint                   v;
        n = (tap_count == 0) ? 1 : ((tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
        pos = newest[ch];
        acc = '0;
        for (int k = 0; k < n; k++) begin
            prod = history[ch*MAX_TAPS + pos] * taps[k];
            acc  = acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
            pos  = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
        end
        v = longint'(signed'(acc));
        v = (v + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return SAMPLE_W'(v);
    endfunction

    always @(posedge aclk) begin
        filtered_t                  got;
        filtered_t                  want;
        logic [CH_W-1:0]            ch;
        logic [CIDX_W-1:0]          idx;
        logic signed [SAMPLE_W-1:0] smp;
        if (!aresetn) begin
            foreach (history[i]) history[i] = '0;
            foreach (newest[i]) newest[i] = 0;
            foreach (taps[i]) taps[i] = '0;
            tap_count = NUM_TAPS_RESET;
            band_mode = MODE_PASS;
            expected_out.delete();
        end else begin
            // Compare first, so a result and a new sample in one cycle never meet.
            if (m_tvalid && m_tready) begin
                got.channel = m_tdata[CH_W-1:0];
                got.value   = m_tdata[CH_W +: SAMPLE_W];
                got.last    = m_tlast;
                result_count++;
                if (expected_out.size() == 0) begin
                    $error("result on channel %0d with nothing expected", got.channel);
                    mismatch_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
                        mismatch_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("filtered: expected %0d, got %0d",
                               $signed(want.value), $signed(got.value));
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("out_last: expected %0d, got %0d", want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ch  = s_tdata[CH_W-1:0];
                smp = s_tdata[CH_W +: SAMPLE_W];
                idx = s_tdata[CIDX_LO +: CIDX_W];
                if (s_tuser == REQ_COEFF) begin
                    if (idx < MAX_TAPS) taps[idx] = s_tdata[CVAL_LO +: COEFF_W];
                end else if (ch < MAX_CHANNELS) begin
                    want.channel = ch;
                    want.last    = s_tlast;
                    case (band_mode)
                        MODE_FILTER: begin
                            newest[ch] = (newest[ch] + 1) % MAX_TAPS;
                            history[ch*MAX_TAPS + newest[ch]] = smp;
                            want.value = fir_output(ch);
                        end
                        MODE_PASS: want.value = smp;
                        default:   want.value = '0;
                    endcase
                    expected_out.push_back(want);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_NUM_TAPS: tap_count = cfg_wdata[NTAPS_W-1:0];
                    CFG_MODE:     band_mode = cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
        end
        errors  <= mismatch_count;
        results <= result_count;
        pending <= expected_out.size();
    end

endmodule

### sim/multichannel_fir_filter_tb.sv
module multichannel_fir_filter_tb;
    import mcfir_pkg::*;

    localparam int HALF_PERIOD  = 2;
    // Longest quiet stretch of a correct run is the memory sweep after reset,
    // far longer than a full-length sum.
    localparam int STALL_LIMIT  = 40000;
    // Coefficient writes yield nothing, so idle time before a register write
    // covers the longest sum the block could still be running.
    localparam int DRAIN_CYCLES = DEF_MAX_TAPS + 16;
    localparam int ITEM_TARGET  = 580;
    localparam int PAD_W        = S_TDATA_W - CH_W - SAMPLE_W - CIDX_W - COEFF_W;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
    localparam int COEFF_MAX  = (1 << (COEFF_W - 1)) - 1;
    localparam int COEFF_MIN  = -(1 << (COEFF_W - 1));

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = REQ_SAMPLE;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int errors;
    int pending;
    int results;

    int sent         = 0;
    int coeff_loads  = 0;
    int settings     = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int rx_span      = 0;
    int rx_kind      = 0;
    bit steady       = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    multichannel_fir_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    multichannel_fir_filter_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .results   (results)
    );

    // Receiver: segments of always-ready, coin-flip, mostly-ready and
    // solid stall, each of random length.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_kind = $urandom_range(0, 3);
            rx_span = $urandom_range(4, 60);
        end
        rx_span--;
        case (rx_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= 1'b0;
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sender bursts: at the start of each burst, optionally drop valid for a gap.
    task automatic idle_gap();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Hold the item until the block takes it.
    task automatic send_item(logic req, logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                             logic [CIDX_W-1:0] idx, logic signed [COEFF_W-1:0] coef,
                             logic last);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {{PAD_W{1'b0}}, coef, idx, smp, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (req == REQ_COEFF) coeff_loads++;
    endtask

    // Fields that the item kind ignores still carry random bits.
    task automatic send_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                               logic last);
        send_item(REQ_SAMPLE, ch, smp, CIDX_W'($urandom), COEFF_W'($urandom), last);
    endtask

    task automatic send_coeff(logic [CIDX_W-1:0] idx, logic signed [COEFF_W-1:0] coef);
        send_item(REQ_COEFF, CH_W'($urandom), SAMPLE_W'($urandom), idx, coef,
                  1'($urandom_range(0, 1)));
    endtask

    // Drop valid and wait out every expected result; with settle, also give a
    // coefficient write or a long sum time to finish before a register write.
    task automatic drain_results(bit settle);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        if (settle) repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] addr, int unsigned value, bit hold);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        if (!hold) cfg_we <= 1'b0;
    endtask

    task automatic configure(int unsigned taps, logic [MODE_W-1:0] mode);
        set_reg(CFG_NUM_TAPS, taps, 1'b1);
        set_reg(CFG_MODE, mode, 1'b0);
        settings++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Small coefficients half of the time, so that sums do not always saturate.
    function automatic logic signed [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return COEFF_MAX;
            1:       return COEFF_MIN;
            2, 3:    return COEFF_W'($urandom);
            default: return COEFF_W'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic [CIDX_W-1:0] pick_index(int span);
        if ($urandom_range(0, 3) == 0) return CIDX_W'($urandom);
        return CIDX_W'($urandom_range(0, (span > 64 ? 64 : span) - 1));
    endfunction

    // One register setting: load the low taps, then samples with some
    // coefficient rewrites mixed in.
    task automatic random_phase(int unsigned taps, logic [MODE_W-1:0] mode);
        int span;
        int count;
        int preload;
        drain_results(1'b1);
        configure(taps, mode);
        span    = (taps == 0) ? 1 : ((taps > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(taps));
        count   = (span > 64) ? $urandom_range(4, 8) : $urandom_range(25, 50);
        preload = (span > 16) ? 16 : span;
        steady  = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < preload && sent < ITEM_TARGET; k++)
            send_coeff(CIDX_W'(k), pick_coeff());
        for (int i = 0; i < count && sent < ITEM_TARGET; i++) begin
            if ($urandom_range(0, 39) == 0) drain_results(1'b0);
            if ($urandom_range(0, 7) == 0)
                send_coeff(pick_index(span), pick_coeff());
            else
                send_sample(CH_W'($urandom), pick_sample(), 1'($urandom_range(0, 7) == 0));
        end
    endtask

    initial begin
        int unsigned       taps;
        logic [MODE_W-1:0] mode;
        int                phase;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings are pass-through with 15 taps: extremes come back as sent.
        send_sample(3'd0, SAMPLE_MAX, 1'b0);
        send_sample(3'd7, SAMPLE_MIN, 1'b1);
        send_sample(3'd3, '0, 1'b0);
        send_sample(3'd5, -1, 1'b1);
        // Load taps at both index extremes and both value extremes.
        send_coeff(10'd0, COEFF_MAX);
        send_coeff(10'd1, COEFF_MIN);
        send_coeff(10'd1023, -1);
        send_coeff(10'd14, 1);
        drain_results(1'b1);

        // Filter with the reset tap count; pass-through must not have touched the lines.
        set_reg(CFG_MODE, MODE_FILTER, 1'b0);
        send_sample(3'd0, SAMPLE_MAX, 1'b0);
        send_sample(3'd0, SAMPLE_MAX, 1'b0);   // taps 0 and 1 nearly cancel
        send_sample(3'd0, SAMPLE_MIN, 1'b0);
        send_sample(3'd7, 1, 1'b1);            // rounds up out of a sub-LSB sum
        send_coeff(10'd1, COEFF_MAX);
        send_sample(3'd2, SAMPLE_MAX, 1'b0);
        send_sample(3'd2, SAMPLE_MAX, 1'b0);   // saturate high
        send_sample(3'd4, SAMPLE_MIN, 1'b0);
        send_sample(3'd4, SAMPLE_MIN, 1'b1);   // saturate low
        drain_results(1'b1);

        // A tap count of zero acts as one.
        configure(0, MODE_FILTER);
        send_sample(3'd0, 12345, 1'b0);
        send_sample(3'd6, -777, 1'b1);
        drain_results(1'b1);

        // Above the table size acts as the full table, wrapping around the line.
        configure(2047, MODE_FILTER);
        send_sample(3'd0, SAMPLE_MIN, 1'b1);
        drain_results(1'b1);

        configure(1, MODE_MUTE);
        send_sample(3'd6, SAMPLE_MAX, 1'b0);
        send_sample(3'd0, -5, 1'b1);
        drain_results(1'b1);

        // The unnamed mode code mutes as well.
        configure(DEF_MAX_TAPS, MODE_RESERVED);
        send_sample(3'd1, 12345, 1'b1);
        send_sample(3'd2, SAMPLE_MIN, 1'b0);

        // Random settings; the first one revisits the lines after mute.
        phase = 0;
        while (sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       taps = 1;
                1:       taps = $urandom_range(100, 400);
                2:       taps = $urandom_range(DEF_MAX_TAPS + 1, 2047);
                default: taps = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 9))
                7:       mode = MODE_PASS;
                8:       mode = MODE_MUTE;
                9:       mode = MODE_RESERVED;
                default: mode = MODE_FILTER;
            endcase
            if (phase == 0) begin
                taps = DEF_MAX_TAPS;
                mode = MODE_FILTER;
            end
            random_phase(taps, mode);
            phase++;
        end

        drain_results(1'b1);
        $display("Summary: %0d transfers in (%0d coefficient loads), %0d filtered samples checked",
                 sent, coeff_loads, results);
        $display("Summary: %0d register settings, tap counts 0 to 2047, all four mode codes",
                 settings);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
